// ===== sv/ftfs_pkg.sv =====
package ftfs_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int ALPHA_BITS = 16;
  localparam int STEPS_W    = 8;
  localparam int COUNT_W    = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIM_PERIOD    = 2'd0,
    CFG_RENDER_PERIOD = 2'd1,
    CFG_MAX_STEPS     = 2'd2,
    CFG_MAX_ELAPSED   = 2'd3
  } cfg_idx_e;

  localparam logic CMD_ADVANCE = 1'b0;
  localparam logic CMD_CLEAR   = 1'b1;

  localparam logic [31:0]        RST_SIM_PERIOD    = 32'd1000000;
  localparam logic [31:0]        RST_RENDER_PERIOD = 32'd1000000;
  localparam logic [STEPS_W-1:0] RST_MAX_STEPS     = 8'd8;
  localparam logic [31:0]        RST_MAX_ELAPSED   = 32'd250000000;

  typedef struct packed {
    logic [31:0]        sim_period;
    logic [31:0]        render_period;
    logic [STEPS_W-1:0] max_steps;
    logic [31:0]        max_elapsed;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctl_t;

endpackage

// ===== sv/ftfs_cfg.sv =====
module ftfs_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ftfs_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ftfs_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output ftfs_pkg::cfg_t                   cfg_o
);

  ftfs_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sim_period    <= ftfs_pkg::RST_SIM_PERIOD;
      cfg_q.render_period <= ftfs_pkg::RST_RENDER_PERIOD;
      cfg_q.max_steps     <= ftfs_pkg::RST_MAX_STEPS;
      cfg_q.max_elapsed   <= ftfs_pkg::RST_MAX_ELAPSED;
    end else if (cfg_we_i) begin
      case (ftfs_pkg::cfg_idx_e'(cfg_index_i))
        ftfs_pkg::CFG_SIM_PERIOD:    cfg_q.sim_period    <= cfg_data_i[31:0];
        ftfs_pkg::CFG_RENDER_PERIOD: cfg_q.render_period <= cfg_data_i[31:0];
        ftfs_pkg::CFG_MAX_STEPS:     cfg_q.max_steps     <= cfg_data_i[ftfs_pkg::STEPS_W-1:0];
        ftfs_pkg::CFG_MAX_ELAPSED:   cfg_q.max_elapsed   <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/ftfs_div.sv =====
// restoring divider, one quotient bit per cycle while ctl_i.step is set
module ftfs_div #(
  parameter int TIME_WIDTH = 32,
  localparam int DW = TIME_WIDTH + 1 + ftfs_pkg::ALPHA_BITS
) (
  input  logic                  clk_i,
  input  ftfs_pkg::div_ctl_t    ctl_i,
  input  logic [DW-1:0]         dividend_i,
  input  logic [TIME_WIDTH-1:0] divisor_i,
  output logic [DW-1:0]         quot_o,
  output logic [TIME_WIDTH-1:0] rem_o
);

  logic [DW-1:0]         dq_q;
  logic [TIME_WIDTH-1:0] rem_q;
  logic [TIME_WIDTH-1:0] div_q;
  logic [TIME_WIDTH:0]   trial;
  logic [TIME_WIDTH:0]   diff;
  logic                  ge;

  assign trial = {rem_q, dq_q[DW-1]};
  assign ge    = trial >= {1'b0, div_q};
  assign diff  = trial - {1'b0, div_q};

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (ctl_i.step) begin
      rem_q <= ge ? diff[TIME_WIDTH-1:0] : trial[TIME_WIDTH-1:0];
      dq_q  <= {dq_q[DW-2:0], ge};
    end
  end

  assign quot_o = dq_q;
  assign rem_o  = rem_q;

endmodule

// ===== sv/fixed_timestep_frame_scheduler_top.sv =====
// channel  | handshake                 | word
// ---------+---------------------------+-------------------------------------------
// in       | in_valid_i / in_stall_o   | command_i, elapsed_i
// out      | out_valid_o / out_stall_i | sim_steps_o, dropped_steps_o, frames_due_o,
//          |                           | alpha_o, sim_frame_o, ren_frame_o
// cfg      | cfg_we_i                  | cfg_index_i, cfg_data_i
//
// Advance word: before out_valid_o, the shared bit-serial divider forms a
// TIME_WIDTH+17-bit quotient for steps and alpha, then a TIME_WIDTH+1-bit
// quotient for render frames. A clear word skips the divider.
// One word in flight; a finished word waits in the output register while the
// next is taken. Reset clears state and loads config defaults.
module fixed_timestep_frame_scheduler_top #(
  parameter int TIME_WIDTH  = 32,
  parameter int FRAME_WIDTH = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ftfs_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ftfs_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             command_i,
  input  logic [31:0]                      elapsed_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [ftfs_pkg::STEPS_W-1:0]     sim_steps_o,
  output logic [31:0]                      dropped_steps_o,
  output logic [31:0]                      frames_due_o,
  output logic [ftfs_pkg::ALPHA_BITS-1:0]  alpha_o,
  output logic [ftfs_pkg::COUNT_W-1:0]     sim_frame_o,
  output logic [ftfs_pkg::COUNT_W-1:0]     ren_frame_o
);

  localparam int AW = TIME_WIDTH + 1;
  localparam int DW = AW + ftfs_pkg::ALPHA_BITS;
  localparam int CW = $clog2(DW + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SLOAD,
    ST_SDIV,
    ST_RLOAD,
    ST_RDIV,
    ST_FIN
  } state_e;

  state_e                            state_q;
  logic [CW-1:0]                     cnt_q;
  logic                              clr_q;
  logic [AW-1:0]                     sim_acc_q;
  logic [AW-1:0]                     ren_acc_q;
  logic [FRAME_WIDTH-1:0]            sim_cnt_q;
  logic [FRAME_WIDTH-1:0]            ren_cnt_q;
  logic [ftfs_pkg::STEPS_W-1:0]      steps_q;
  logic [31:0]                       dropped_q;
  logic [ftfs_pkg::ALPHA_BITS-1:0]   alpha_q;

  logic                              out_valid_q;
  logic [ftfs_pkg::STEPS_W-1:0]      o_steps_q;
  logic [31:0]                       o_dropped_q;
  logic [31:0]                       o_frames_q;
  logic [ftfs_pkg::ALPHA_BITS-1:0]   o_alpha_q;
  logic [ftfs_pkg::COUNT_W-1:0]      o_sim_frame_q;
  logic [ftfs_pkg::COUNT_W-1:0]      o_ren_frame_q;

  ftfs_pkg::cfg_t                    cfg;
  ftfs_pkg::div_ctl_t                div_ctl;
  logic [DW-1:0]                     div_dividend;
  logic [TIME_WIDTH-1:0]             div_divisor;
  logic [DW-1:0]                     quot;
  logic [TIME_WIDTH-1:0]             rem;

  logic [TIME_WIDTH-1:0]             e_in;
  logic [TIME_WIDTH-1:0]             e_lim;
  logic [TIME_WIDTH-1:0]             e_cl;
  logic [AW-1:0]                     sim_sum;
  logic [AW-1:0]                     ren_sum;
  logic [TIME_WIDTH-1:0]             sp_raw;
  logic [TIME_WIDTH-1:0]             rp_raw;
  logic [TIME_WIDTH-1:0]             sp;
  logic [TIME_WIDTH-1:0]             rp;
  logic [AW-1:0]                     whole;
  logic [AW-1:0]                     ms_w;
  logic [AW-1:0]                     excess;
  logic [63:0]                       excess_ext;
  logic [31:0]                       dropped_sat;
  logic [AW-1:0]                     frames;
  logic [63:0]                       frames_ext;
  logic [31:0]                       frames_sat;
  logic [FRAME_WIDTH-1:0]            sim_cnt_nx;
  logic [FRAME_WIDTH-1:0]            ren_cnt_nx;
  logic                              in_take;
  logic                              out_free;

  ftfs_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ftfs_div #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .ctl_i      (div_ctl),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  assign e_in    = TIME_WIDTH'(elapsed_i);
  assign e_lim   = TIME_WIDTH'(cfg.max_elapsed);
  assign e_cl    = (e_in > e_lim) ? e_lim : e_in;
  assign sim_sum = sim_acc_q + AW'(e_cl);
  assign ren_sum = ren_acc_q + AW'(e_cl);

  // a zero period counts as one tick
  assign sp_raw = TIME_WIDTH'(cfg.sim_period);
  assign rp_raw = TIME_WIDTH'(cfg.render_period);
  assign sp     = (sp_raw == '0) ? TIME_WIDTH'(1) : sp_raw;
  assign rp     = (rp_raw == '0) ? TIME_WIDTH'(1) : rp_raw;

  assign div_ctl.load = (state_q == ST_SLOAD) || (state_q == ST_RLOAD);
  assign div_ctl.step = (state_q == ST_SDIV) || (state_q == ST_RDIV);
  assign div_dividend = (state_q == ST_RLOAD) ? {ren_acc_q, {ftfs_pkg::ALPHA_BITS{1'b0}}}
                                              : {sim_acc_q, {ftfs_pkg::ALPHA_BITS{1'b0}}};
  assign div_divisor  = (state_q == ST_RLOAD) ? rp : sp;

  assign whole       = quot[DW-1:ftfs_pkg::ALPHA_BITS];
  assign ms_w        = AW'(cfg.max_steps);
  assign excess      = whole - ms_w;
  assign excess_ext  = 64'(excess);
  assign dropped_sat = (excess_ext > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF
                                                              : excess_ext[31:0];

  assign frames     = quot[AW-1:0];
  assign frames_ext = 64'(frames);
  assign frames_sat = (frames_ext > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF
                                                             : frames_ext[31:0];

  assign sim_cnt_nx = sim_cnt_q + FRAME_WIDTH'(steps_q);
  assign ren_cnt_nx = ren_cnt_q + FRAME_WIDTH'(frames);

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cnt_q         <= '0;
      clr_q         <= 1'b0;
      sim_acc_q     <= '0;
      ren_acc_q     <= '0;
      sim_cnt_q     <= '0;
      ren_cnt_q     <= '0;
      steps_q       <= '0;
      dropped_q     <= '0;
      alpha_q       <= '0;
      out_valid_q   <= 1'b0;
      o_steps_q     <= '0;
      o_dropped_q   <= '0;
      o_frames_q    <= '0;
      o_alpha_q     <= '0;
      o_sim_frame_q <= '0;
      o_ren_frame_q <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != ST_FIN)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_take) begin
            if (command_i == ftfs_pkg::CMD_CLEAR) begin
              sim_acc_q <= '0;
              ren_acc_q <= '0;
              sim_cnt_q <= '0;
              ren_cnt_q <= '0;
              clr_q     <= 1'b1;
              state_q   <= ST_FIN;
            end else begin
              sim_acc_q <= sim_sum;
              ren_acc_q <= ren_sum;
              clr_q     <= 1'b0;
              state_q   <= ST_SLOAD;
            end
          end
        end
        ST_SLOAD: begin
          cnt_q   <= '0;
          state_q <= ST_SDIV;
        end
        ST_SDIV: begin
          cnt_q <= cnt_q + CW'(1);
          // integer part done: remainder is the new sim accumulator
          if (cnt_q == CW'(AW)) begin
            sim_acc_q <= AW'(rem);
          end
          if (cnt_q == CW'(DW - 1)) begin
            state_q <= ST_RLOAD;
          end
        end
        ST_RLOAD: begin
          if (whole < ms_w) begin
            steps_q   <= whole[ftfs_pkg::STEPS_W-1:0];
            dropped_q <= '0;
          end else begin
            steps_q   <= cfg.max_steps;
            dropped_q <= dropped_sat;
          end
          alpha_q <= quot[ftfs_pkg::ALPHA_BITS-1:0];
          cnt_q   <= '0;
          state_q <= ST_RDIV;
        end
        ST_RDIV: begin
          cnt_q <= cnt_q + CW'(1);
          if (cnt_q == CW'(AW - 1)) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            if (clr_q) begin
              o_steps_q     <= '0;
              o_dropped_q   <= '0;
              o_frames_q    <= '0;
              o_alpha_q     <= '0;
              o_sim_frame_q <= '0;
              o_ren_frame_q <= '0;
            end else begin
              o_steps_q     <= steps_q;
              o_dropped_q   <= dropped_q;
              o_frames_q    <= frames_sat;
              o_alpha_q     <= alpha_q;
              o_sim_frame_q <= ftfs_pkg::COUNT_W'(sim_cnt_nx);
              o_ren_frame_q <= ftfs_pkg::COUNT_W'(ren_cnt_nx);
              sim_cnt_q     <= sim_cnt_nx;
              ren_cnt_q     <= ren_cnt_nx;
              ren_acc_q     <= AW'(rem);
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sim_steps_o     = o_steps_q;
  assign dropped_steps_o = o_dropped_q;
  assign frames_due_o    = o_frames_q;
  assign alpha_o         = o_alpha_q;
  assign sim_frame_o     = o_sim_frame_q;
  assign ren_frame_o     = o_ren_frame_q;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

  typedef struct {
    logic        cmd;
    logic [31:0] elapsed;
  } tick_word_t;

  typedef struct packed {
    logic [ftfs_pkg::STEPS_W-1:0]    steps;
    logic [31:0]                     dropped;
    logic [31:0]                     frames;
    logic [ftfs_pkg::ALPHA_BITS-1:0] alpha;
    logic [ftfs_pkg::COUNT_W-1:0]    sim_frame;
    logic [ftfs_pkg::COUNT_W-1:0]    ren_frame;
  } frame_report_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_we_i = 1'b0;
  logic [ftfs_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [ftfs_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                            in_valid_i = 1'b0;
  logic                            in_stall_o;
  logic                            command_i = ftfs_pkg::CMD_ADVANCE;
  logic [31:0]                     elapsed_i = '0;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  logic [ftfs_pkg::STEPS_W-1:0]    sim_steps_o;
  logic [31:0]                     dropped_steps_o;
  logic [31:0]                     frames_due_o;
  logic [ftfs_pkg::ALPHA_BITS-1:0] alpha_o;
  logic [ftfs_pkg::COUNT_W-1:0]    sim_frame_o;
  logic [ftfs_pkg::COUNT_W-1:0]    ren_frame_o;
  frame_report_t                   got;

  fixed_timestep_frame_scheduler_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .command_i       (command_i),
    .elapsed_i       (elapsed_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .sim_steps_o     (sim_steps_o),
    .dropped_steps_o (dropped_steps_o),
    .frames_due_o    (frames_due_o),
    .alpha_o         (alpha_o),
    .sim_frame_o     (sim_frame_o),
    .ren_frame_o     (ren_frame_o)
  );

  assign got = {sim_steps_o, dropped_steps_o, frames_due_o, alpha_o, sim_frame_o,
                ren_frame_o};

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // scheduler mirror
  logic [31:0]                  m_sim_period    = ftfs_pkg::RST_SIM_PERIOD;
  logic [31:0]                  m_render_period = ftfs_pkg::RST_RENDER_PERIOD;
  logic [ftfs_pkg::STEPS_W-1:0] m_max_steps     = ftfs_pkg::RST_MAX_STEPS;
  logic [31:0]                  m_max_elapsed   = ftfs_pkg::RST_MAX_ELAPSED;
  logic [63:0]                  sim_acc = '0;
  logic [63:0]                  render_acc = '0;
  logic [31:0]                  sim_count = '0;
  logic [31:0]                  render_count = '0;

  tick_word_t    word_q[$];
  frame_report_t report_q[$];
  int unsigned   errors = 0;

  bit          word_taken = 1'b0;
  int unsigned tx_gap = 0;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;
  bit          rx_hold_req = 1'b0;
  bit          rx_hold_seen = 1'b0;
  int unsigned rx_hold_cnt = 0;
  int unsigned rx_stall_cnt = 0;

  function automatic frame_report_t schedule_frame(logic cmd, logic [31:0] elapsed);
    logic [63:0]   e, sp, rp, whole, steps, dropped, frames, alpha;
    frame_report_t r;
    r = '0;
    if (cmd == ftfs_pkg::CMD_CLEAR) begin
      sim_acc = '0;
      render_acc = '0;
      sim_count = '0;
      render_count = '0;
      return r;
    end
    e = {32'd0, elapsed};
    if (e > {32'd0, m_max_elapsed}) e = {32'd0, m_max_elapsed};
    sp = (m_sim_period == 0) ? 64'd1 : {32'd0, m_sim_period};
    rp = (m_render_period == 0) ? 64'd1 : {32'd0, m_render_period};
    sim_acc = sim_acc + e;
    render_acc = render_acc + e;
    whole = sim_acc / sp;
    steps = (whole < {56'd0, m_max_steps}) ? whole : {56'd0, m_max_steps};
    dropped = whole - steps;
    sim_acc = sim_acc % sp;
    frames = render_acc / rp;
    render_acc = render_acc % rp;
    sim_count = sim_count + steps[31:0];
    render_count = render_count + frames[31:0];
    alpha = (sim_acc << 16) / sp;
    if (alpha > 64'hFFFF) alpha = 64'hFFFF;
    r.steps = steps[ftfs_pkg::STEPS_W-1:0];
    r.dropped = (dropped > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : dropped[31:0];
    r.frames = (frames > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : frames[31:0];
    r.alpha = alpha[ftfs_pkg::ALPHA_BITS-1:0];
    r.sim_frame = sim_count;
    r.ren_frame = render_count;
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(15, 60);
  endfunction

  function automatic logic [31:0] pick_time();
    case ($urandom_range(0, 4))
      0: return $urandom_range(1, 64);
      1: return $urandom_range(1000, 2000000);
      2: return $urandom | 32'd1;
      3: return 32'hFFFF_FFFF;
      default: return ($urandom_range(1, 15)) << $urandom_range(0, 28);
    endcase
  endfunction

  function automatic logic [31:0] pick_elapsed();
    logic [63:0] sp, hi;
    sp = (m_sim_period == 0) ? 64'd1 : {32'd0, m_sim_period};
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom;
      3, 4, 5: begin
        hi = sp * 2;
        if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
        return $urandom_range(0, hi[31:0]);
      end
      6: return $urandom_range(0, 15);
      7: return 32'd0;
      8: return 32'hFFFF_FFFF;
      default: begin
        hi = sp * $urandom_range(1, 300);
        if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
        return hi[31:0];
      end
    endcase
  endfunction

  // sender: words change on the falling edge
  always @(negedge clk_i) begin
    tick_word_t w;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || word_taken) begin
      if (tx_gap > 0) begin
        in_valid_i <= 1'b0;
        tx_gap <= tx_gap - 1;
      end else if (word_q.size() > 0) begin
        w = word_q.pop_front();
        in_valid_i <= 1'b1;
        command_i <= w.cmd;
        elapsed_i <= w.elapsed;
        tx_gap <= tx_calm ? 0 : pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver stall
  always @(negedge clk_i) begin
    int unsigned n;
    if (rx_hold_req && !rx_hold_seen) begin
      rx_hold_seen <= 1'b1;
      rx_hold_cnt <= 1500;
      out_stall_i <= 1'b1;
    end else if (rx_hold_cnt > 0) begin
      rx_hold_cnt <= rx_hold_cnt - 1;
      out_stall_i <= 1'b1;
    end else if (rx_stall_cnt > 0) begin
      rx_stall_cnt <= rx_stall_cnt - 1;
      out_stall_i <= 1'b1;
    end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
      n = pick_gap();
      rx_stall_cnt <= (n > 0) ? n - 1 : 0;
      out_stall_i <= (n > 0);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // prediction on input accept, check on output accept
  always @(posedge clk_i) begin
    frame_report_t exp_r;
    word_taken <= (in_valid_i === 1'b1) && (in_stall_o === 1'b0);
    if (rst_ni && in_valid_i === 1'b1 && in_stall_o === 1'b0)
      report_q.push_back(schedule_frame(command_i, elapsed_i));
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (report_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word steps=%0d dropped=%0d frames=%0d alpha=%0d",
                 $time, got.steps, got.dropped, got.frames, got.alpha);
        $display("%0t:          sim=%0d rnd=%0d", $time, got.sim_frame, got.ren_frame);
      end else begin
        exp_r = report_q.pop_front();
        if (got !== exp_r) begin
          errors++;
          $display("%0t: mismatch exp steps=%0d dropped=%0d frames=%0d alpha=%0d sim=%0d rnd=%0d",
                   $time, exp_r.steps, exp_r.dropped, exp_r.frames, exp_r.alpha,
                   exp_r.sim_frame, exp_r.ren_frame);
          $display("%0t:          got steps=%0d dropped=%0d frames=%0d alpha=%0d sim=%0d rnd=%0d",
                   $time, got.steps, got.dropped, got.frames, got.alpha, got.sim_frame,
                   got.ren_frame);
        end
      end
    end
  end

  task automatic write_reg(ftfs_pkg::cfg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    case (idx)
      ftfs_pkg::CFG_SIM_PERIOD:    m_sim_period = val;
      ftfs_pkg::CFG_RENDER_PERIOD: m_render_period = val;
      ftfs_pkg::CFG_MAX_STEPS:     m_max_steps = val[ftfs_pkg::STEPS_W-1:0];
      default:                     m_max_elapsed = val;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic push_word(logic cmd, logic [31:0] elapsed);
    tick_word_t w;
    w.cmd = cmd;
    w.elapsed = elapsed;
    word_q.push_back(w);
  endtask

  task automatic drain();
    while (word_q.size() > 0 || in_valid_i || report_q.size() > 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
  endtask

  initial begin
    int unsigned n;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset defaults
    push_word(ftfs_pkg::CMD_CLEAR, 32'hFFFF_FFFF);
    push_word(ftfs_pkg::CMD_ADVANCE, 32'd0);
    push_word(ftfs_pkg::CMD_ADVANCE, 32'd1);
    push_word(ftfs_pkg::CMD_ADVANCE, 32'd999999);
    push_word(ftfs_pkg::CMD_ADVANCE, 32'd1000000);
    push_word(ftfs_pkg::CMD_ADVANCE, 32'd8000000);
    push_word(ftfs_pkg::CMD_ADVANCE, 32'd9500000);
    push_word(ftfs_pkg::CMD_ADVANCE, 32'd250000000);
    push_word(ftfs_pkg::CMD_ADVANCE, 32'hFFFF_FFFF);
    push_word(ftfs_pkg::CMD_CLEAR, 32'd0);
    push_word(ftfs_pkg::CMD_ADVANCE, 32'd500000);
    drain();

    // shortest periods, widest cap and clamp
    write_reg(ftfs_pkg::CFG_SIM_PERIOD, 32'd1);
    write_reg(ftfs_pkg::CFG_RENDER_PERIOD, 32'd1);
    write_reg(ftfs_pkg::CFG_MAX_STEPS, 32'd255);
    write_reg(ftfs_pkg::CFG_MAX_ELAPSED, 32'hFFFF_FFFF);
    push_word(ftfs_pkg::CMD_ADVANCE, 32'hFFFF_FFFF);
    push_word(ftfs_pkg::CMD_ADVANCE, 32'd255);
    push_word(ftfs_pkg::CMD_ADVANCE, 32'd256);
    push_word(ftfs_pkg::CMD_CLEAR, 32'h5A5A_A5A5);
    drain();

    // longest periods, accumulator near its top
    write_reg(ftfs_pkg::CFG_SIM_PERIOD, 32'hFFFF_FFFF);
    write_reg(ftfs_pkg::CFG_RENDER_PERIOD, 32'hFFFF_FFFF);
    write_reg(ftfs_pkg::CFG_MAX_STEPS, 32'd1);
    push_word(ftfs_pkg::CMD_ADVANCE, 32'hFFFF_FFFE);
    push_word(ftfs_pkg::CMD_ADVANCE, 32'hFFFF_FFFF);
    push_word(ftfs_pkg::CMD_ADVANCE, 32'hFFFF_FFFF);
    drain();

    // zero registers
    write_reg(ftfs_pkg::CFG_SIM_PERIOD, 32'd0);
    write_reg(ftfs_pkg::CFG_RENDER_PERIOD, 32'd0);
    write_reg(ftfs_pkg::CFG_MAX_STEPS, 32'd0);
    write_reg(ftfs_pkg::CFG_MAX_ELAPSED, 32'd0);
    push_word(ftfs_pkg::CMD_ADVANCE, 32'd5);
    drain();
    write_reg(ftfs_pkg::CFG_MAX_ELAPSED, 32'hFFFF_FFFF);
    push_word(ftfs_pkg::CMD_ADVANCE, 32'd7);
    push_word(ftfs_pkg::CMD_CLEAR, 32'd0);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      write_reg(ftfs_pkg::CFG_SIM_PERIOD, pick_time());
      write_reg(ftfs_pkg::CFG_RENDER_PERIOD, pick_time());
      case ($urandom_range(0, 3))
        0: write_reg(ftfs_pkg::CFG_MAX_STEPS, 32'd1);
        1: write_reg(ftfs_pkg::CFG_MAX_STEPS, 32'd255);
        default: write_reg(ftfs_pkg::CFG_MAX_STEPS, $urandom_range(1, 255));
      endcase
      case ($urandom_range(0, 3))
        0: write_reg(ftfs_pkg::CFG_MAX_ELAPSED, 32'hFFFF_FFFF);
        1: write_reg(ftfs_pkg::CFG_MAX_ELAPSED, $urandom_range(1, 100));
        default: write_reg(ftfs_pkg::CFG_MAX_ELAPSED, pick_time());
      endcase
      tx_calm = (ph % 4 == 1) || (ph == 3);
      rx_calm = (ph % 4 == 2);
      if (ph == 3) rx_hold_req = 1'b1;
      n = $urandom_range(100, 136);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 99) < 3) push_word(ftfs_pkg::CMD_CLEAR, $urandom);
        else push_word(ftfs_pkg::CMD_ADVANCE, pick_elapsed());
      end
      drain();
      rx_hold_req = 1'b0;
    end

    if (report_q.size() != 0) errors++;
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
